@@ hw/rtl/mvt_pkg.sv @@
// ----------------------------------------------------------------------------
// mvt_pkg: shared types for the 4x4 matrix-vector transform
// Holds the word and accumulator types and the beat that travels through
// the cell chain.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned DIM    = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic               load;
    logic [3:0]         idx;
    word_t              val;
    word_t [DIM-1:0]    vec;
    acc_t  [DIM-1:0]    acc;
  } beat_t;

endpackage

@@ hw/rtl/mat4_vector_transform.sv @@
// ----------------------------------------------------------------------------
// mat4_vector_transform: 4x4 fixed-point matrix times vector
// A chain of four column cells holds the matrix and builds the four row sums
// of each transform beat; load beats travel the same chain and write their
// entry when they pass the cell that owns it.
//
//   channel | dir | tdata (low bit up)                          | tuser
//   in_     | in  | entry_index, entry_value, vec_x..vec_w, pad | req_type
//   out_    | out | out_x, out_y, out_z, out_w                  | -
//
// One beat is accepted per cycle while the output is not stalled; a transform
// result passes through two register stages per cell and then the output
// register.
// Reset loads the identity matrix and empties the chain.
// A stalled output fills the chain stage by stage; bubbles are collapsed.
// ----------------------------------------------------------------------------
module mat4_vector_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,   // entry_index, entry_value, vec_x, vec_y, vec_z, vec_w
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // out_x, out_y, out_z, out_w
);

  mvt_pkg::beat_t                 chain_beat [mvt_pkg::DIM+1];
  logic [mvt_pkg::DIM:0]          chain_valid;
  logic [mvt_pkg::DIM:0]          chain_ready;

  always_comb begin
    chain_beat[0].load = !in_tuser;
    chain_beat[0].idx  = in_tdata[3:0];
    chain_beat[0].val  = in_tdata[35:4];
    chain_beat[0].vec  = in_tdata[163:36];
    chain_beat[0].acc  = '0;
  end

  assign chain_valid[0] = in_tvalid;
  assign in_tready      = chain_ready[0];

  for (genvar k = 0; k < mvt_pkg::DIM; k++) begin : g_cell
    mvt_cell #(
      .COL       (k),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_beat  (chain_beat[k]),
      .up_ready (chain_ready[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_beat  (chain_beat[k+1]),
      .dn_ready (chain_ready[k+1])
    );
  end

  mvt_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (chain_valid[mvt_pkg::DIM]),
    .up_beat    (chain_beat[mvt_pkg::DIM]),
    .up_ready   (chain_ready[mvt_pkg::DIM]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ hw/rtl/mvt_cell.sv @@
// ----------------------------------------------------------------------------
// mvt_cell: one column cell of the transform chain
// Holds one matrix column, multiplies it by its vector component and adds
// the products to the running row sums handed on by the previous cell.
// ----------------------------------------------------------------------------
module mvt_cell #(
  parameter int unsigned COL       = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  mvt_pkg::beat_t up_beat,
  output logic          up_ready,
  output logic          dn_valid,
  output mvt_pkg::beat_t dn_beat,
  input  logic          dn_ready
);

  mvt_pkg::word_t [mvt_pkg::DIM-1:0] col_r;
  mvt_pkg::prod_t [mvt_pkg::DIM-1:0] prod_r;
  mvt_pkg::beat_t                   b1_r;
  mvt_pkg::beat_t                   b2_r;
  mvt_pkg::beat_t                   b2_nxt;
  logic                             v1_r;
  logic                             v2_r;
  logic                             s1_rdy;
  logic                             s2_rdy;
  logic                             up_take;
  logic                             col_wr;

  assign s2_rdy   = !v2_r || dn_ready;
  assign s1_rdy   = !v1_r || s2_rdy;
  assign up_ready = s1_rdy;
  assign up_take  = up_valid && s1_rdy;
  assign col_wr   = up_take && up_beat.load && (up_beat.idx[3:2] == 2'(COL));
  assign dn_valid = v2_r;
  assign dn_beat  = b2_r;

  always_comb begin
    b2_nxt = b1_r;
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      b2_nxt.acc[r] = b1_r.acc[r] + mvt_pkg::acc_t'(prod_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        col_r[r] <= (r == COL) ? mvt_pkg::word_t'(64'd1 << FRAC_BITS) : '0;
      end
    end else begin
      if (s1_rdy) begin
        v1_r <= up_valid;
      end
      if (s2_rdy) begin
        v2_r <= v1_r;
      end
      if (col_wr) begin
        col_r[up_beat.idx[1:0]] <= up_beat.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      b1_r <= up_beat;
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        prod_r[r] <= $signed(col_r[r]) * $signed(up_beat.vec[COL]);
      end
    end
    if (s2_rdy && v1_r) begin
      b2_r <= b2_nxt;
    end
  end

endmodule

@@ hw/rtl/mvt_out.sv @@
// ----------------------------------------------------------------------------
// mvt_out: rescale, saturate and output register
// Shifts the row sums by the fraction bits, clamps them to the signed 32-bit
// range and holds the result beat; load beats end here without a result.
// ----------------------------------------------------------------------------
module mvt_out #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  mvt_pkg::beat_t up_beat,
  output logic           up_ready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [127:0]   out_tdata
);

  mvt_pkg::word_t [mvt_pkg::DIM-1:0] res_nxt;
  mvt_pkg::word_t [mvt_pkg::DIM-1:0] res_r;
  logic                              out_valid_r;
  logic                              res_take;
  mvt_pkg::acc_t                     q;

  assign up_ready   = up_beat.load || !out_valid_r || out_tready;
  assign res_take   = up_valid && up_ready && !up_beat.load;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  always_comb begin
    q = '0;
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      q = up_beat.acc[r] >>> FRAC_BITS;
      if ((&q[mvt_pkg::ACC_W-1:mvt_pkg::WORD_W-1]) ||
          !(|q[mvt_pkg::ACC_W-1:mvt_pkg::WORD_W-1])) begin
        res_nxt[r] = q[mvt_pkg::WORD_W-1:0];
      end else if (q[mvt_pkg::ACC_W-1]) begin
        res_nxt[r] = {1'b1, {(mvt_pkg::WORD_W-1){1'b0}}};
      end else begin
        res_nxt[r] = {1'b0, {(mvt_pkg::WORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4x4 fixed-point matrix-vector transform
// Drives load and transform beats with random gaps and output stalls. An
// in-order model of the matrix store predicts every transform result, and
// each output beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          FRAC_BITS    = 16;
  localparam int          LATENCY      = 9;
  localparam int unsigned RANDOM_ITEMS = 1600;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XFORM = 1'b1;

  localparam mvt_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam mvt_pkg::word_t WORD_MIN = 32'sh8000_0000;
  localparam mvt_pkg::word_t ONE      = 32'sh0001_0000;
  localparam mvt_pkg::acc_t  SAT_HI   = mvt_pkg::acc_t'(WORD_MAX);
  localparam mvt_pkg::acc_t  SAT_LO   = mvt_pkg::acc_t'(WORD_MIN);

  typedef struct packed {
    mvt_pkg::word_t w;
    mvt_pkg::word_t z;
    mvt_pkg::word_t y;
    mvt_pkg::word_t x;
  } vec4_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  mvt_pkg::word_t coef [16];
  vec4_t          pending_products [$];
  int unsigned    mismatches = 0;
  bit             gaps_on = 1'b0;
  int unsigned    ready_left = 0;

  mat4_vector_transform #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic vec4_t mk_vec(mvt_pkg::word_t x, mvt_pkg::word_t y,
                                   mvt_pkg::word_t z, mvt_pkg::word_t w);
    return {w, z, y, x};
  endfunction

  function automatic void reset_coef();
    for (int i = 0; i < 16; i++) begin
      coef[i] = (i % 5 == 0) ? ONE : '0;
    end
  endfunction

  // Each row sum is formed exactly, shifted right arithmetically, then clipped.
  function automatic vec4_t transform_vector(vec4_t v);
    mvt_pkg::word_t comp [4];
    mvt_pkg::word_t res [4];
    mvt_pkg::acc_t  sum;
    mvt_pkg::prod_t p;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    comp[3] = v.w;
    for (int r = 0; r < 4; r++) begin
      sum = '0;
      for (int k = 0; k < 4; k++) begin
        p = coef[k * 4 + r] * comp[k];
        sum = sum + p;
      end
      sum = sum >>> FRAC_BITS;
      if (sum > SAT_HI) begin
        res[r] = WORD_MAX;
      end else if (sum < SAT_LO) begin
        res[r] = WORD_MIN;
      end else begin
        res[r] = sum[31:0];
      end
    end
    return {res[3], res[2], res[1], res[0]};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 60) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic mvt_pkg::word_t rand_word(int unsigned wide_pct);
    int unsigned r;
    int          s;
    r = $urandom_range(99);
    if (r < 5) begin
      case ($urandom_range(5))
        0: return WORD_MAX;
        1: return WORD_MIN;
        2: return '0;
        3: return -1;
        4: return ONE;
        default: return -ONE;
      endcase
    end else if (r < 5 + wide_pct) begin
      return $urandom();
    end
    s = int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    return s;
  endfunction

  function automatic vec4_t rand_vec();
    return mk_vec(rand_word(30), rand_word(30), rand_word(30), rand_word(30));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Drives one beat, holds it until accepted, then updates the model.
  task automatic send_beat(input logic req, input logic [3:0] idx,
                           input mvt_pkg::word_t val, input vec4_t v);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, v, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == REQ_LOAD) begin
      coef[idx] = val;
    end else begin
      pending_products.push_back(transform_vector(v));
    end
  endtask

  task automatic sender_pause();
    int unsigned n;
    n = pick_gap();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
  endtask

  task automatic test_identity_reset();
    send_beat(REQ_XFORM, 4'd15, WORD_MAX, mk_vec(WORD_MAX, WORD_MIN, 32'sd1, -32'sd1));
    send_beat(REQ_XFORM, 4'd0, WORD_MIN, mk_vec(WORD_MIN, WORD_MAX, '0, ONE));
    drain_results();
  endtask

  task automatic test_saturation();
    send_beat(REQ_LOAD, 4'd0, WORD_MAX, rand_vec());
    send_beat(REQ_LOAD, 4'd4, WORD_MAX, rand_vec());
    send_beat(REQ_LOAD, 4'd8, WORD_MAX, rand_vec());
    send_beat(REQ_LOAD, 4'd12, WORD_MAX, rand_vec());
    send_beat(REQ_XFORM, 4'd3, 32'sd77, mk_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send_beat(REQ_XFORM, 4'd9, -32'sd5, mk_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    drain_results();
  endtask

  task automatic test_rounding_and_corners();
    send_beat(REQ_LOAD, 4'd0, 32'sd1, rand_vec());
    send_beat(REQ_XFORM, 4'd0, '0, mk_vec(-32'sd1, '0, '0, '0));
    send_beat(REQ_XFORM, 4'd0, '0, mk_vec(32'sd1, '0, '0, '0));
    send_beat(REQ_LOAD, 4'd15, WORD_MIN, rand_vec());
    send_beat(REQ_XFORM, 4'd15, '0, mk_vec('0, -32'sd1, 32'sd3, WORD_MIN));
    drain_results();
  endtask

  // Scale-and-translate matrix times the columns of a second matrix.
  task automatic test_matrix_product();
    send_beat(REQ_LOAD, 4'd0, 32'sh0002_0000, rand_vec());
    send_beat(REQ_LOAD, 4'd4, '0, rand_vec());
    send_beat(REQ_LOAD, 4'd8, '0, rand_vec());
    send_beat(REQ_LOAD, 4'd12, 32'sh0003_0000, rand_vec());
    send_beat(REQ_LOAD, 4'd13, -32'sh0001_8000, rand_vec());
    send_beat(REQ_LOAD, 4'd15, ONE, rand_vec());
    send_beat(REQ_XFORM, 4'd0, '0, mk_vec(ONE, '0, 32'sh0000_8000, '0));
    send_beat(REQ_XFORM, 4'd0, '0, mk_vec('0, -ONE, '0, '0));
    send_beat(REQ_XFORM, 4'd0, '0, mk_vec(32'sh0000_4000, '0, ONE, '0));
    send_beat(REQ_XFORM, 4'd0, '0, mk_vec(32'sh0001_2345, -32'sh0000_0777, '0, ONE));
    drain_results();
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    int unsigned blk;
    sent = 0;
    blk = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = (blk % 3 != 0);
      if (blk == 4) begin
        drain_results();
      end
      if ($urandom_range(3) != 0) begin
        for (int i = 0; i < 16; i++) begin
          send_beat(REQ_LOAD, i[3:0], rand_word(8), rand_vec());
          sender_pause();
        end
        sent += 16;
      end
      repeat ($urandom_range(20, 120)) begin
        if ($urandom_range(9) == 0) begin
          send_beat(REQ_LOAD, 4'($urandom()), rand_word(30), rand_vec());
        end else begin
          send_beat(REQ_XFORM, 4'($urandom()), $urandom(), rand_vec());
        end
        sender_pause();
        sent++;
      end
      blk++;
    end
  endtask

  always @(posedge clk) begin : ready_gen
    int unsigned stall;
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (out_tready) begin
      stall = pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        ready_left <= stall - 1;
      end else begin
        ready_left <= $urandom_range(0, 7);
      end
    end else begin
      out_tready <= 1'b1;
      ready_left <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin : result_check
    vec4_t got;
    vec4_t want;
    string names [4];
    names = '{"out_x", "out_y", "out_z", "out_w"};
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", out_tdata));
      end else begin
        want = pending_products.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[32 * i +: 32] !== want[32 * i +: 32]) begin
            report_mismatch($sformatf("%s got %h expected %h", names[i],
                                      got[32 * i +: 32], want[32 * i +: 32]));
          end
        end
      end
    end
  end

  initial begin
    reset_coef();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_reset();
    test_saturation();
    test_rounding_and_corners();
    test_matrix_product();
    test_random_stream();
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("TIMEOUT: %0d results still outstanding", pending_products.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mvt_pkg.sv
hw/rtl/mvt_cell.sv
hw/rtl/mvt_out.sv
hw/rtl/mat4_vector_transform.sv
dv/tb_top.sv
